>>> hw/rtl/rsi_pkg.sv
package rsi_pkg;

    localparam int MAG_W = 50;
    localparam int Q_W = 31;
    localparam int DIV_STAGES = 31;
    localparam int MIN_T = 7;
    localparam int FLIP_TH = 65;

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_CENTER_X = 3'd4;
    localparam logic [2:0] REG_CENTER_Y = 3'd5;
    localparam logic [2:0] REG_CENTER_Z = 3'd6;
    localparam logic [2:0] REG_SIDE     = 3'd7;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        side_length;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } ray_t;

    typedef struct packed {
        logic             miss;
        logic             flip;
        logic [MAG_W-1:0] a_mag;
        logic [MAG_W-1:0] b_mag;
        ray_t             ray;
    } front_item_t;

    typedef struct packed {
        logic             miss;
        logic             flip;
        logic             sat;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] b;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   nlow;
        ray_t             ray;
    } div_t;

    typedef struct packed {
        logic               hit;
        logic [Q_W-1:0]     distance;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
    } result_t;

endpackage

>>> hw/rtl/rsi_queue.sv
module rsi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wptr_reg, wptr_next;
    logic [AW:0]      rptr_reg, rptr_next;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[AW] != rptr_reg[AW]) &&
                   (wptr_reg[AW-1:0] == rptr_reg[AW-1:0]);
    assign rdata = mem_reg[rptr_reg[AW-1:0]];

    always_comb
    begin
        wptr_next = wptr_reg + (AW+1)'(push && !full);
        rptr_next = rptr_reg + (AW+1)'(pop && !empty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wptr_reg[AW-1:0]] <= wdata;
        end
    end
endmodule

>>> hw/rtl/rsi_front.sv
module rsi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  rsi_pkg::cfg_t       cfg,
    input  logic                push,
    input  rsi_pkg::ray_t       ray,
    output logic                full,
    input  logic                mid_full,
    output logic                mid_push,
    output rsi_pkg::front_item_t mid_item
);
    import rsi_pkg::*;

    logic               adv;
    logic signed [63:0] mo [3];
    logic signed [63:0] md [3];
    logic signed [32:0] co [3];
    logic signed [64:0] mc [3];

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [47:0] pno_reg [3];
    logic signed [47:0] pnd_reg [3];
    logic signed [48:0] pcs_reg [3];
    ray_t               ray1_reg, ray2_reg;
    logic signed [MAG_W-1:0] num_reg, num_next;
    logic signed [MAG_W-1:0] den_reg, den_next;
    logic signed [50:0] s_reg, s_next;
    front_item_t        item_reg, item_next;

    assign adv      = !(v3_reg && mid_full);
    assign full     = !adv;
    assign mid_push = v3_reg && !mid_full;
    assign mid_item = item_reg;

    always_comb
    begin
        co[0] = 33'(cfg.center_x) - 33'(ray.ox);
        co[1] = 33'(cfg.center_y) - 33'(ray.oy);
        co[2] = 33'(cfg.center_z) - 33'(ray.oz);
        mo[0] = 64'(cfg.normal_x) * 64'(ray.ox);
        mo[1] = 64'(cfg.normal_y) * 64'(ray.oy);
        mo[2] = 64'(cfg.normal_z) * 64'(ray.oz);
        md[0] = 64'(cfg.normal_x) * 64'(ray.dx);
        md[1] = 64'(cfg.normal_y) * 64'(ray.dy);
        md[2] = 64'(cfg.normal_z) * 64'(ray.dz);
        mc[0] = 65'(co[0]) * 65'(cfg.normal_x);
        mc[1] = 65'(co[1]) * 65'(cfg.normal_y);
        mc[2] = 65'(co[2]) * 65'(cfg.normal_z);
    end

    always_comb
    begin
        num_next = MAG_W'(pno_reg[0]) + MAG_W'(pno_reg[1]) + MAG_W'(pno_reg[2])
                 + MAG_W'(cfg.plane_offset);
        den_next = MAG_W'(pnd_reg[0]) + MAG_W'(pnd_reg[1]) + MAG_W'(pnd_reg[2]);
        s_next   = 51'(pcs_reg[0]) + 51'(pcs_reg[1]) + 51'(pcs_reg[2]);
    end

    always_comb
    begin
        item_next.miss  = (den_reg == '0) || (num_reg == '0) ||
                          (num_reg[MAG_W-1] == den_reg[MAG_W-1]);
        item_next.flip  = (s_reg > 51'(FLIP_TH));
        item_next.a_mag = num_reg[MAG_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        item_next.b_mag = den_reg[MAG_W-1] ? MAG_W'(-den_reg) : MAG_W'(den_reg);
        item_next.ray   = ray2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pno_reg[i] <= mo[i][63:16];
                pnd_reg[i] <= md[i][63:16];
                pcs_reg[i] <= mc[i][64:16];
            end
            ray1_reg <= ray;
            num_reg  <= num_next;
            den_reg  <= den_next;
            s_reg    <= s_next;
            ray2_reg <= ray1_reg;
            item_reg <= item_next;
        end
    end
endmodule

>>> hw/rtl/rsi_back.sv
module rsi_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsi_pkg::cfg_t        cfg,
    input  logic                 mid_empty,
    input  rsi_pkg::front_item_t mid_item,
    output logic                 mid_pop,
    input  logic                 out_full,
    output logic                 out_push,
    output rsi_pkg::result_t     out_item
);
    import rsi_pkg::*;

    function automatic div_t div_step(div_t x);
        logic [MAG_W:0] trial;
        div_t           y;
        y     = x;
        trial = {x.rem, x.nlow[Q_W-1]};
        if (trial >= {1'b0, x.b})
        begin
            y.rem = MAG_W'(trial - {1'b0, x.b});
            y.q   = {x.q[Q_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = trial[MAG_W-1:0];
            y.q   = {x.q[Q_W-2:0], 1'b0};
        end
        y.nlow = {x.nlow[Q_W-2:0], 1'b0};
        return y;
    endfunction

    logic               adv;
    div_t               init_next;
    div_t               stage_reg [DIV_STAGES+1];
    logic               sv_reg [DIV_STAGES+1];
    div_t               last;
    logic [Q_W-1:0]     t;
    logic signed [63:0] tp [3];

    logic               hv_reg, cv_reg;
    logic [Q_W-1:0]     ht_reg;
    logic signed [47:0] hp_reg [3];
    logic               hmiss_reg, hflip_reg;
    ray_t               hray_reg;

    logic signed [48:0] diff [3];
    logic [48:0]        adiff [3];
    logic               inb;
    result_t            res_next, res_reg;

    assign adv      = !(cv_reg && out_full);
    assign mid_pop  = adv && !mid_empty;
    assign out_push = cv_reg && !out_full;
    assign out_item = res_reg;

    always_comb
    begin
        init_next.miss = mid_item.miss;
        init_next.flip = mid_item.flip;
        init_next.rem  = {15'd0, mid_item.a_mag[MAG_W-1:15]};
        init_next.b    = mid_item.b_mag;
        init_next.sat  = ({15'd0, mid_item.a_mag[MAG_W-1:15]} >= mid_item.b_mag);
        init_next.q    = '0;
        init_next.nlow = {mid_item.a_mag[14:0], 16'd0};
        init_next.ray  = mid_item.ray;
    end

    always_comb
    begin
        last  = stage_reg[DIV_STAGES];
        t     = last.sat ? {Q_W{1'b1}} : last.q;
        tp[0] = 64'($signed({1'b0, t})) * 64'(last.ray.dx);
        tp[1] = 64'($signed({1'b0, t})) * 64'(last.ray.dy);
        tp[2] = 64'($signed({1'b0, t})) * 64'(last.ray.dz);
    end

    always_comb
    begin
        diff[0] = 49'(hray_reg.ox) + 49'(hp_reg[0]) - 49'(cfg.center_x);
        diff[1] = 49'(hray_reg.oy) + 49'(hp_reg[1]) - 49'(cfg.center_y);
        diff[2] = 49'(hray_reg.oz) + 49'(hp_reg[2]) - 49'(cfg.center_z);
        inb = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            adiff[i] = diff[i][48] ? 49'(-diff[i]) : 49'(diff[i]);
            if (adiff[i] > 49'(cfg.side_length[30:1]))
            begin
                inb = 1'b0;
            end
        end
        res_next.hit      = !hmiss_reg && inb;
        res_next.distance = res_next.hit ? ht_reg : '0;
        res_next.nx       = '0;
        res_next.ny       = '0;
        res_next.nz       = '0;
        if (res_next.hit)
        begin
            res_next.nx = hflip_reg ? -cfg.normal_x : cfg.normal_x;
            res_next.ny = hflip_reg ? -cfg.normal_y : cfg.normal_y;
            res_next.nz = hflip_reg ? -cfg.normal_z : cfg.normal_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            hv_reg <= 1'b0;
            cv_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= !mid_empty;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                sv_reg[i+1] <= sv_reg[i];
            end
            hv_reg <= sv_reg[DIV_STAGES];
            cv_reg <= hv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= init_next;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                stage_reg[i+1] <= div_step(stage_reg[i]);
            end
            ht_reg    <= t;
            hmiss_reg <= last.miss || (t < Q_W'(MIN_T));
            hflip_reg <= last.flip;
            hray_reg  <= last.ray;
            for (int i = 0; i < 3; i++)
            begin
                hp_reg[i] <= tp[i][63:16];
            end
            res_reg <= res_next;
        end
    end
endmodule

>>> hw/rtl/ray_square_intersect.sv
// channel  | handshake              | beat
// ray in   | push / full            | origin_x..z, dir_x..z
// result   | pop / empty            | hit, distance, hit_normal_x..z
// config   | psel penable pwrite .. | paddr[4:2] selects register, pwdata
//
// One ray per cycle sustained while full stays low; from push to result a ray passes
// 3 dot-product stages, the mid queue, 31 divider stages and 2 bounds stages.
// The 31-stage restoring divider sets the latency.
// Reset clears all config registers to zero and empties both queues.
// Front and back stall separately; full rises when the mid queue backs up.
module ray_square_intersect (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic               pop,
    output logic               empty,
    output logic               hit,
    output logic [30:0]        distance,
    output logic signed [31:0] hit_normal_x,
    output logic signed [31:0] hit_normal_y,
    output logic signed [31:0] hit_normal_z
);
    import rsi_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    ray_t        in_ray;
    logic        mid_push, mid_pop, mid_full, mid_empty;
    front_item_t mid_wr, mid_rd;
    logic [$bits(front_item_t)-1:0] mid_rdata;
    logic        out_push, out_full;
    result_t     out_wr, out_rd;
    logic [$bits(result_t)-1:0] out_rdata;

    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                REG_NORMAL_X: cfg_next.normal_x     = pwdata;
                REG_NORMAL_Y: cfg_next.normal_y     = pwdata;
                REG_NORMAL_Z: cfg_next.normal_z     = pwdata;
                REG_OFFSET:   cfg_next.plane_offset = pwdata;
                REG_CENTER_X: cfg_next.center_x     = pwdata;
                REG_CENTER_Y: cfg_next.center_y     = pwdata;
                REG_CENTER_Z: cfg_next.center_z     = pwdata;
                REG_SIDE:     cfg_next.side_length  = pwdata[30:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_NORMAL_X: prdata = cfg_reg.normal_x;
            REG_NORMAL_Y: prdata = cfg_reg.normal_y;
            REG_NORMAL_Z: prdata = cfg_reg.normal_z;
            REG_OFFSET:   prdata = cfg_reg.plane_offset;
            REG_CENTER_X: prdata = cfg_reg.center_x;
            REG_CENTER_Y: prdata = cfg_reg.center_y;
            REG_CENTER_Z: prdata = cfg_reg.center_z;
            REG_SIDE:     prdata = {1'b0, cfg_reg.side_length};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        in_ray.ox = origin_x;
        in_ray.oy = origin_y;
        in_ray.oz = origin_z;
        in_ray.dx = dir_x;
        in_ray.dy = dir_y;
        in_ray.dz = dir_z;
    end

    rsi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .ray      (in_ray),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_wr)
    );

    rsi_queue #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (4)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wr),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty),
        .full  (mid_full)
    );

    assign mid_rd = front_item_t'(mid_rdata);

    rsi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_wr)
    );

    rsi_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (4)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wr),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty),
        .full  (out_full)
    );

    assign out_rd       = result_t'(out_rdata);
    assign hit          = out_rd.hit;
    assign distance     = out_rd.distance;
    assign hit_normal_x = out_rd.nx;
    assign hit_normal_y = out_rd.ny;
    assign hit_normal_z = out_rd.nz;

    a_hit_min_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && hit) |-> (distance >= 31'(MIN_T)))
        else $error("hit below minimum distance");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !hit) |-> (distance == '0 && hit_normal_x == '0 &&
                              hit_normal_y == '0 && hit_normal_z == '0))
        else $error("miss result not cleared");

    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_full && !mid_pop) |=> mid_full || !$past(mid_push))
        else $error("mid queue overrun");
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rsi_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    ray_t               cur_ray = '0;
    logic               pop = 1'b0;
    logic               empty;
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] hit_normal_x;
    logic signed [31:0] hit_normal_y;
    logic signed [31:0] hit_normal_z;

    logic signed [31:0] cfg_n [3];
    logic signed [31:0] cfg_c [3];
    logic signed [31:0] cfg_off;
    logic [30:0]        cfg_side;

    ray_t    ray_queue [$];
    result_t hit_queue [$];
    int      errors = 0;
    int      rays_in = 0;
    int      send_idle = 19;
    int      recv_idle = 88;
    int      hold_cycles = 0;
    bit      hold_done = 0;
    bit      took = 0;

    ray_square_intersect u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .origin_x(cur_ray.ox), .origin_y(cur_ray.oy), .origin_z(cur_ray.oz),
        .dir_x(cur_ray.dx), .dir_y(cur_ray.dy), .dir_z(cur_ray.dz),
        .pop(pop), .empty(empty), .hit(hit), .distance(distance),
        .hit_normal_x(hit_normal_x), .hit_normal_y(hit_normal_y),
        .hit_normal_z(hit_normal_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic result_t trace_ray(ray_t r);
        longint             o [3];
        longint             d [3];
        longint             n [3];
        longint             c [3];
        longint             num;
        longint             den;
        longint             tq;
        longint             dif;
        longint             h;
        logic [95:0]        a;
        logic [95:0]        b;
        logic signed [95:0] s;
        logic signed [95:0] ce;
        logic signed [95:0] ne;
        result_t            res;
        res = '0;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
        for (int i = 0; i < 3; i++)
        begin
            n[i] = cfg_n[i];
            c[i] = cfg_c[i];
        end
        num = cfg_off;
        den = 0;
        for (int i = 0; i < 3; i++)
        begin
            num += (o[i] * n[i]) >>> 16;
            den += (d[i] * n[i]) >>> 16;
        end
        if (den == 0 || num == 0 || ((num > 0) == (den > 0)))
            return res;
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        if (a / b >= 32768)
            tq = 64'h7FFF_FFFF;
        else
            tq = longint'((a << 16) / b);
        if (tq < MIN_T)
            return res;
        h = cfg_side >> 1;
        for (int i = 0; i < 3; i++)
        begin
            dif = o[i] + ((tq * d[i]) >>> 16) - c[i];
            if (dif < 0)
                dif = -dif;
            if (dif > h)
                return res;
        end
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            ce = c[i] - o[i];
            ne = n[i];
            s += (ce * ne) >>> 16;
        end
        res.hit = 1'b1;
        res.distance = tq[30:0];
        res.nx = (s > FLIP_TH) ? -cfg_n[0] : cfg_n[0];
        res.ny = (s > FLIP_TH) ? -cfg_n[1] : cfg_n[1];
        res.nz = (s > FLIP_TH) ? -cfg_n[2] : cfg_n[2];
        return res;
    endfunction

    // input side
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            hit_queue.push_back(trace_ray(cur_ray));
            rays_in++;
            took = 1;
        end
    end

    always @(negedge clk)
    begin
        if (rays_in < 270)
        begin
            send_idle = 19;
            recv_idle = 88;
        end
        else if (rays_in < 540)
        begin
            send_idle = 88;
            recv_idle = 19;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (rst_n && (!push || took))
        begin
            took = 0;
            if (ray_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                cur_ray <= ray_queue.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // result side
    always @(negedge clk)
    begin
        if (!hold_done && rays_in >= 150)
        begin
            hold_done = 1;
            hold_cycles = 400;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (hit_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat hit=%0d dist=%h", hit, distance);
            end
            else
            begin
                want = hit_queue.pop_front();
                if (hit !== want.hit || distance !== want.distance ||
                    hit_normal_x !== want.nx || hit_normal_y !== want.ny ||
                    hit_normal_z !== want.nz)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %b %h %h %h %h got %b %h %h %h %h",
                                 want.hit, want.distance, want.nx, want.ny, want.nz,
                                 hit, distance, hit_normal_x, hit_normal_y,
                                 hit_normal_z);
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_NORMAL_X: cfg_n[0] = val;
            REG_NORMAL_Y: cfg_n[1] = val;
            REG_NORMAL_Z: cfg_n[2] = val;
            REG_OFFSET:   cfg_off = val;
            REG_CENTER_X: cfg_c[0] = val;
            REG_CENTER_Y: cfg_c[1] = val;
            REG_CENTER_Z: cfg_c[2] = val;
            REG_SIDE:     cfg_side = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_square(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                              logic [31:0] off, logic [31:0] cx, logic [31:0] cy,
                              logic [31:0] cz, logic [31:0] side);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_OFFSET, off);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_SIDE, side);
    endtask

    // checked just after the rising edge, once driver and monitor have settled
    task automatic drain();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (ray_queue.size() != 0 || push || hit_queue.size() != 0);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom_range(65536 * 8) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    // aimed rays land near the square center; the rest is noise
    task automatic queue_rays(int count);
        ray_t   r;
        longint tgt;
        longint dd;
        longint tt;
        longint h;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 65)
            begin
                h = cfg_side >> 1;
                if (h > 64'd16_000_000)
                    h = 64'd16_000_000;
                tt = $urandom_range(20 * 65536, 1);
                for (int i = 0; i < 3; i++)
                begin
                    tgt = longint'(cfg_c[i]) + longint'($urandom_range(2 * h)) - h;
                    dd = longint'($urandom_range(8 * 65536)) - 4 * 65536;
                    case (i)
                        0: begin r.dx = 32'(dd); r.ox = 32'(tgt - ((tt * dd) >>> 16)); end
                        1: begin r.dy = 32'(dd); r.oy = 32'(tgt - ((tt * dd) >>> 16)); end
                        default:
                        begin
                            r.dz = 32'(dd);
                            r.oz = 32'(tgt - ((tt * dd) >>> 16));
                        end
                    endcase
                end
            end
            else
            begin
                r.ox = rand_word(); r.oy = rand_word(); r.oz = rand_word();
                r.dx = rand_word(); r.dy = rand_word(); r.dz = rand_word();
            end
            ray_queue.push_back(r);
        end
    endtask

    task automatic queue_edge_rays();
        logic [31:0] v [4];
        v[0] = 32'h8000_0000; v[1] = 32'h7FFF_FFFF; v[2] = 32'h0; v[3] = 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                ray_queue.push_back('{v[i], v[i], v[i], v[j], v[j], v[j]});
        // straight onto the plane along z, from above and below
        ray_queue.push_back('{32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'hFFFF_0000});
        ray_queue.push_back('{32'h0, 32'h0, 32'hFFFB_0000, 32'h0, 32'h0, 32'h0001_0000});
        // tiny distance, below the minimum
        ray_queue.push_back('{32'h0, 32'h0, 32'h0000_0003, 32'h0, 32'h0, 32'hFFFF_0000});
        // far away, distance saturates
        ray_queue.push_back('{32'h0, 32'h0, 32'h7FFF_0000, 32'h0, 32'h0, 32'hFFFF_FFFF});
        // parallel to the plane
        ray_queue.push_back('{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0});
        // exactly on the square edge
        ray_queue.push_back('{32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000});
    endtask

    initial
    begin
        cfg_n = '{0, 0, 0};
        cfg_c = '{0, 0, 0};
        cfg_off = 0;
        cfg_side = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        queue_rays(20);
        drain();

        set_square(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0004_0000);
        queue_edge_rays();
        drain();

        set_square(32'h0, 32'h0, 32'h0001_0000, 32'hFFF6_0000, 32'h0003_0000,
                   32'hFFFE_0000, 32'h000A_0000, 32'h0040_0000);
        queue_rays(250);
        drain();

        set_square(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h7FFF_FFFF);
        queue_rays(200);
        drain();

        set_square(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        queue_rays(60);
        drain();

        set_square($urandom_range(65536 * 2) - 65536, $urandom_range(65536 * 2) - 65536,
                   32'h0000_B000, $urandom, $urandom_range(65536 * 10),
                   $urandom_range(65536 * 10), $urandom_range(65536 * 10),
                   $urandom_range(65536 * 30));
        queue_rays(300);
        drain();

        if (hit_queue.size() != 0)
            errors++;
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
